// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL file that carries concurrent checks, the interpolator.
// Every macro expects i_clk and the active-low i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("keyframe track assertion failed");

// Next-cycle implication, disabled while reset is held
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("keyframe track assertion failed");

// Invariant that holds at every edge out of reset
`define ASSERT_ALWAYS(label, cond) \
    `ASSERT_IMPL(label, 1'b1, cond)

`endif

// ===== hw/rtl/ktrk_pkg.sv =====
// Shared constants, codes and types for the keyframe track interpolator.
// No dependencies; used by every RTL file of the block but ktrk_ram.
package ktrk_pkg;

    // Track capacity and derived widths
    localparam int MAX_FRAMES = 4096;
    localparam int ADDR_W     = $clog2(MAX_FRAMES);
    localparam int CNT_W      = $clog2(MAX_FRAMES + 1);

    // Field widths
    localparam int COORD_W    = 16;
    localparam int TIME_W     = 32;
    localparam int QUOT_W     = TIME_W - 1;
    localparam int IVL_W      = 24;
    localparam int FRAC_W     = 8;
    localparam int Q8_W       = COORD_W + FRAC_W;
    localparam int FRAME_W    = 3 * COORD_W;

    localparam logic [IVL_W-1:0] IVL_RESET = IVL_W'(100000);

    // Request command codes
    typedef enum logic [0:0] {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    // Which path produced a result
    typedef enum logic [1:0] {
        WHERE_LERP  = 2'd0,
        WHERE_FIRST = 2'd1,
        WHERE_LAST  = 2'd2
    } t_where;

    // One stored keyframe
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] rot;
    } t_frame;

endpackage

// ===== hw/rtl/keyframe_track_interpolator.sv =====
// Keyframe track interpolator: a load request appends one keyframe (x, y,
// rotation) to a 4096-entry track, start_new restarting the track; a load to a
// full track is dropped. A query request returns one pose in Q8 through the
// bit-serial units: a first-frame answer comes from two store reads, a
// last-frame answer from the time/interval divider (31 steps and a done pulse)
// then the store reads, and an interpolated answer from the divider, two store
// reads, then 16 multiply and 24 divide steps in the three lanes, side by side.
// Queries on an empty track give no result. A finished result waits in the
// output register while the next request is taken; no reset sweep is needed.
// Depends on ktrk_pkg, ktrk_ram, ktrk_div, ktrk_lerp and assert_macros.svh.
`include "assert_macros.svh"

module keyframe_track_interpolator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ktrk_pkg::IVL_W-1:0]          i_cfg_interval_ticks,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_cmd,
    input  logic                                i_start_new,
    input  logic signed [ktrk_pkg::COORD_W-1:0] i_frame_x,
    input  logic signed [ktrk_pkg::COORD_W-1:0] i_frame_y,
    input  logic signed [ktrk_pkg::COORD_W-1:0] i_frame_rot,
    input  logic signed [ktrk_pkg::TIME_W-1:0]  i_race_time,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [ktrk_pkg::Q8_W-1:0]    o_pos_x_q8,
    output logic signed [ktrk_pkg::Q8_W-1:0]    o_pos_y_q8,
    output logic signed [ktrk_pkg::Q8_W-1:0]    o_rot_q8,
    output logic [1:0]                          o_where_case
);

    localparam int CNT_W   = ktrk_pkg::CNT_W;
    localparam int ADDR_W  = ktrk_pkg::ADDR_W;
    localparam int IVL_W   = ktrk_pkg::IVL_W;
    localparam int QUOT_W  = ktrk_pkg::QUOT_W;
    localparam int TIME_W  = ktrk_pkg::TIME_W;
    localparam int Q8_W    = ktrk_pkg::Q8_W;
    localparam int FRAC_W  = ktrk_pkg::FRAC_W;
    localparam int FRAME_W = ktrk_pkg::FRAME_W;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DIV   = 7'b0000010,
        S_RDA   = 7'b0000100,
        S_RDB   = 7'b0001000,
        S_START = 7'b0010000,
        S_LERP  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [IVL_W-1:0]   r_interval;
    logic [ADDR_W-1:0]  r_addr;
    ktrk_pkg::t_where   r_where;
    ktrk_pkg::t_frame   r_a;
    logic               r_out_valid;
    logic [Q8_W-1:0]    r_out_x;
    logic [Q8_W-1:0]    r_out_y;
    logic [Q8_W-1:0]    r_out_rot;
    ktrk_pkg::t_where   r_out_where;

    logic               in_acc;
    logic               is_load;
    logic [CNT_W-1:0]   load_base;
    logic               load_ok;
    logic               time_pos;
    logic               div_start;
    logic               div_done;
    logic [QUOT_W-1:0]  div_quot;
    logic [IVL_W-1:0]   div_rem;
    logic [IVL_W-1:0]   ivl_eff;
    logic [CNT_W-1:0]   last_idx;
    logic               idx_past;
    logic               out_free;
    logic               lane_start;
    logic               x_done;
    logic               y_done;
    logic               rot_done;
    logic [Q8_W-1:0]    x_q8;
    logic [Q8_W-1:0]    y_q8;
    logic [Q8_W-1:0]    rot_q8;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_raddr;
    ktrk_pkg::t_frame   ram_wdata;
    logic [FRAME_W-1:0] ram_rdata;
    ktrk_pkg::t_frame   rd_frame;

    // Request decode and store addressing
    always_comb begin
        in_acc    = i_in_valid && o_in_ready;
        is_load   = (i_cmd == ktrk_pkg::CMD_LOAD);
        load_base = i_start_new ? '0 : r_count;
        load_ok   = (load_base < CNT_W'(ktrk_pkg::MAX_FRAMES));
        ram_we    = (r_state == S_IDLE) && in_acc && is_load && load_ok;
        ram_wdata = '{x: i_frame_x, y: i_frame_y, rot: i_frame_rot};
        ivl_eff   = (r_interval == '0) ? IVL_W'(1) : r_interval;
        time_pos  = !i_race_time[TIME_W-1] && (i_race_time != '0);
        div_start = (r_state == S_IDLE) && in_acc && !is_load && (r_count != '0)
                    && time_pos && (r_count != CNT_W'(1));
        last_idx  = r_count - CNT_W'(1);
        idx_past  = (div_quot >= QUOT_W'(last_idx));
        ram_raddr = (r_state == S_RDB) ? (r_addr + ADDR_W'(1)) : r_addr;
        rd_frame  = ram_rdata;
        out_free  = !r_out_valid || i_out_ready;
        o_in_ready  = (r_state == S_IDLE);
        o_cfg_ready = 1'b1;
    end

    // Sequencer next state
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        lane_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (is_load) begin
                        if (load_ok) begin
                            n_count = load_base + CNT_W'(1);
                        end
                    end else if (r_count != '0) begin
                        n_state = div_start ? S_DIV : S_RDA;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_RDA;
                end
            end
            S_RDA: begin
                n_state = S_RDB;
            end
            S_RDB: begin
                n_state = S_START;
            end
            S_START: begin
                if (r_where == ktrk_pkg::WHERE_LERP) begin
                    lane_start = 1'b1;
                    n_state    = S_LERP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_LERP: begin
                if (x_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_interval  <= ktrk_pkg::IVL_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_valid) begin
                r_interval <= i_cfg_interval_ticks;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Query payload: frame selection, left neighbour, result register
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_acc) begin
            r_addr  <= '0;
            r_where <= ktrk_pkg::WHERE_FIRST;
        end
        if (r_state == S_DIV && div_done) begin
            if (idx_past) begin
                r_addr  <= last_idx[ADDR_W-1:0];
                r_where <= ktrk_pkg::WHERE_LAST;
            end else begin
                r_addr  <= div_quot[ADDR_W-1:0];
                r_where <= ktrk_pkg::WHERE_LERP;
            end
        end
        if (r_state == S_RDB) begin
            r_a <= rd_frame;
        end
        if (r_state == S_DONE && out_free) begin
            r_out_where <= r_where;
            if (r_where == ktrk_pkg::WHERE_LERP) begin
                r_out_x   <= x_q8;
                r_out_y   <= y_q8;
                r_out_rot <= rot_q8;
            end else begin
                r_out_x   <= {r_a.x, {FRAC_W{1'b0}}};
                r_out_y   <= {r_a.y, {FRAC_W{1'b0}}};
                r_out_rot <= {r_a.rot, {FRAC_W{1'b0}}};
            end
        end
    end

    // Keyframe store
    ktrk_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (ktrk_pkg::MAX_FRAMES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (load_base[ADDR_W-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Time / interval into index and remainder
    ktrk_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_race_time[QUOT_W-1:0]),
        .i_divisor  (ivl_eff),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // Three interpolation lanes; right neighbour comes straight from the store
    ktrk_lerp u_lerp_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (lane_start),
        .i_a     (r_a.x),
        .i_b     (rd_frame.x),
        .i_rem   (div_rem),
        .i_ivl   (ivl_eff),
        .o_done  (x_done),
        .o_q8    (x_q8)
    );

    ktrk_lerp u_lerp_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (lane_start),
        .i_a     (r_a.y),
        .i_b     (rd_frame.y),
        .i_rem   (div_rem),
        .i_ivl   (ivl_eff),
        .o_done  (y_done),
        .o_q8    (y_q8)
    );

    ktrk_lerp u_lerp_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (lane_start),
        .i_a     (r_a.rot),
        .i_b     (rd_frame.rot),
        .i_rem   (div_rem),
        .i_ivl   (ivl_eff),
        .o_done  (rot_done),
        .o_q8    (rot_q8)
    );

    assign o_out_valid  = r_out_valid;
    assign o_pos_x_q8   = r_out_x;
    assign o_pos_y_q8   = r_out_y;
    assign o_rot_q8     = r_out_rot;
    assign o_where_case = r_out_where;

    // Checks
    `ASSERT_IMPL(a_lanes_in_step, x_done, y_done && rot_done)
    `ASSERT_IMPL(a_div_done_in_div, div_done, r_state == S_DIV)
    `ASSERT_IMPL(a_result_from_done, $rose(r_out_valid), $past(r_state) == S_DONE)
    `ASSERT_ALWAYS(a_count_bound, r_count <= CNT_W'(ktrk_pkg::MAX_FRAMES))

endmodule

// ===== hw/rtl/ktrk_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the keyframe store.
module ktrk_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/ktrk_div.sv =====
// Bit-serial restoring divider: time / interval, one quotient bit a cycle.
// Depends on ktrk_pkg for widths.
module ktrk_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ktrk_pkg::QUOT_W-1:0]   i_dividend,
    input  logic [ktrk_pkg::IVL_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [ktrk_pkg::QUOT_W-1:0]   o_quot,
    output logic [ktrk_pkg::IVL_W-1:0]    o_rem
);

    localparam int QUOT_W = ktrk_pkg::QUOT_W;
    localparam int IVL_W  = ktrk_pkg::IVL_W;
    localparam int STEP_W = $clog2(QUOT_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [IVL_W-1:0]  r_dvs;
    logic [IVL_W-1:0]  r_part;
    logic [QUOT_W-1:0] r_q;

    logic [IVL_W:0]    n_trial;
    logic [IVL_W:0]    n_diff;
    logic              n_ge;

    // One restoring step: bring in the next dividend bit, trial subtract
    always_comb begin
        n_trial = {r_part, r_q[QUOT_W-1]};
        n_diff  = n_trial - {1'b0, r_dvs};
        n_ge    = (n_trial >= {1'b0, r_dvs});
    end

    // Step counter and completion pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(QUOT_W - 1);
            end else if (r_busy) begin
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step - STEP_W'(1);
                end
            end
        end
    end

    // Dividend shifts out at the top as quotient bits shift in at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvs  <= i_divisor;
            r_part <= '0;
            r_q    <= i_dividend;
        end else if (r_busy) begin
            r_part <= n_ge ? n_diff[IVL_W-1:0] : n_trial[IVL_W-1:0];
            r_q    <= {r_q[QUOT_W-2:0], n_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_part;

endmodule

// ===== hw/rtl/ktrk_lerp.sv =====
// One interpolation lane: a*256 + trunc((b-a)*rem*256/interval).
// Serial shift-add multiply then serial restoring divide; uses ktrk_pkg.
module ktrk_lerp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [ktrk_pkg::COORD_W-1:0] i_a,
    input  logic signed [ktrk_pkg::COORD_W-1:0] i_b,
    input  logic [ktrk_pkg::IVL_W-1:0]          i_rem,
    input  logic [ktrk_pkg::IVL_W-1:0]          i_ivl,
    output logic                                o_done,
    output logic signed [ktrk_pkg::Q8_W-1:0]    o_q8
);

    localparam int COORD_W   = ktrk_pkg::COORD_W;
    localparam int IVL_W     = ktrk_pkg::IVL_W;
    localparam int FRAC_W    = ktrk_pkg::FRAC_W;
    localparam int Q8_W      = ktrk_pkg::Q8_W;
    localparam int MUL_STEPS = COORD_W;
    localparam int DIV_STEPS = Q8_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    typedef enum logic [3:0] {
        L_IDLE = 4'b0001,
        L_MUL  = 4'b0010,
        L_DIV  = 4'b0100,
        L_FIN  = 4'b1000
    } t_lane_st;

    t_lane_st                  r_st;
    logic [STEP_W-1:0]         r_step;
    logic                      r_done;
    logic signed [COORD_W-1:0] r_a;
    logic                      r_neg;
    logic [IVL_W-1:0]          r_ivl;
    logic [IVL_W-1:0]          r_rem;
    logic [IVL_W-1:0]          r_hi;
    logic [Q8_W-1:0]           r_mq;
    logic [Q8_W-1:0]           r_q8;

    logic [COORD_W:0]          n_diff;
    logic [COORD_W:0]          n_mag;
    logic [IVL_W:0]            n_sum;
    logic [COORD_W-1:0]        n_lo;
    logic [IVL_W:0]            n_trial;
    logic [IVL_W:0]            n_sub;
    logic                      n_ge;
    logic [Q8_W-1:0]           n_base;

    // Start: magnitude and sign of b - a
    // Multiply step: add rem on the low multiplier bit, shift right
    // Divide step: restoring, one quotient bit
    always_comb begin
        n_diff  = {i_b[COORD_W-1], i_b} - {i_a[COORD_W-1], i_a};
        n_mag   = n_diff[COORD_W] ? (~n_diff + (COORD_W+1)'(1)) : n_diff;
        n_sum   = {1'b0, r_hi} + (r_mq[0] ? {1'b0, r_rem} : '0);
        n_lo    = {n_sum[0], r_mq[COORD_W-1:1]};
        n_trial = {r_hi, r_mq[Q8_W-1]};
        n_sub   = n_trial - {1'b0, r_ivl};
        n_ge    = (n_trial >= {1'b0, r_ivl});
        n_base  = {r_a, {FRAC_W{1'b0}}};
    end

    // Phase sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= L_IDLE;
            r_step <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_st)
                L_IDLE: begin
                    if (i_start) begin
                        r_st   <= L_MUL;
                        r_step <= STEP_W'(MUL_STEPS - 1);
                    end
                end
                L_MUL: begin
                    if (r_step == '0) begin
                        r_st   <= L_DIV;
                        r_step <= STEP_W'(DIV_STEPS - 1);
                    end else begin
                        r_step <= r_step - STEP_W'(1);
                    end
                end
                L_DIV: begin
                    if (r_step == '0) begin
                        r_st <= L_FIN;
                    end else begin
                        r_step <= r_step - STEP_W'(1);
                    end
                end
                L_FIN: begin
                    r_st   <= L_IDLE;
                    r_done <= 1'b1;
                end
                default: begin
                    r_st <= L_IDLE;
                end
            endcase
        end
    end

    // Datapath; product top half is below the interval, so it seeds the divide
    always_ff @(posedge i_clk) begin
        if (r_st == L_IDLE && i_start) begin
            r_a   <= i_a;
            r_neg <= n_diff[COORD_W];
            r_ivl <= i_ivl;
            r_rem <= i_rem;
            r_hi  <= '0;
            r_mq  <= {{FRAC_W{1'b0}}, n_mag[COORD_W-1:0]};
        end else if (r_st == L_MUL) begin
            r_hi <= n_sum[IVL_W:1];
            if (r_step == '0) begin
                r_mq <= {n_lo, {FRAC_W{1'b0}}};
            end else begin
                r_mq <= {{FRAC_W{1'b0}}, n_lo};
            end
        end else if (r_st == L_DIV) begin
            r_hi <= n_ge ? n_sub[IVL_W-1:0] : n_trial[IVL_W-1:0];
            r_mq <= {r_mq[Q8_W-2:0], n_ge};
        end else if (r_st == L_FIN) begin
            r_q8 <= r_neg ? (n_base - r_mq) : (n_base + r_mq);
        end
    end

    assign o_done = r_done;
    assign o_q8   = r_q8;

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for keyframe_track_interpolator: loads keyframe tracks, queries poses
// and compares each result with a behavioural track model kept in a small scoreboard class.
// Depends on ktrk_pkg and the keyframe_track_interpolator RTL.
module tb;
    import ktrk_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 100;    // beyond the slowest (interpolated) query
    localparam int MAX_REPORTS   = 100;

    // One expected or observed pose
    typedef struct {
        logic signed [Q8_W-1:0] x;
        logic signed [Q8_W-1:0] y;
        logic signed [Q8_W-1:0] rot;
        t_where                 where;
    } t_pose;

    // Track model plus the queue of poses still owed by the block
    class pose_tracker;
        t_frame           track [MAX_FRAMES];
        int unsigned      track_len = 0;
        logic [IVL_W-1:0] interval = IVL_RESET;
        t_pose            pending_poses [$];
        int unsigned      errors = 0;
        int unsigned      loads = 0;
        int unsigned      queries = 0;
        int unsigned      dropped = 0;
        int unsigned      where_seen [3] = '{0, 0, 0};

        task report_mismatch(string msg);
            if (errors < MAX_REPORTS)
                $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        function t_pose keyframe_pose(t_frame f, t_where w);
            t_pose p;
            p.x     = {f.x, 8'h00};
            p.y     = {f.y, 8'h00};
            p.rot   = {f.rot, 8'h00};
            p.where = w;
            return p;
        endfunction

        // a in Q8 plus the truncated share of the step to b
        function logic signed [Q8_W-1:0] blend_coord(longint a, longint b, longint rem,
                                                      longint ivl);
            longint step;
            step = (b - a) * rem * 256;
            return Q8_W'(a * 256 + step / ivl);
        endfunction

        function void note_request(t_cmd c, logic sn, t_frame f, logic signed [TIME_W-1:0] t);
            longint ivl;
            longint idx;
            longint rem;
            t_pose  p;
            if (c == CMD_LOAD) begin
                loads++;
                if (sn)
                    track_len = 0;
                if (track_len < MAX_FRAMES) begin
                    track[track_len] = f;
                    track_len++;
                end else begin
                    dropped++;
                end
                return;
            end
            queries++;
            // empty track: nothing comes back
            if (track_len == 0)
                return;
            ivl = (interval == '0) ? 1 : longint'(interval);
            if (t <= 0 || track_len == 1) begin
                p = keyframe_pose(track[0], WHERE_FIRST);
            end else begin
                idx = longint'(t) / ivl;
                rem = longint'(t) % ivl;
                if (idx >= longint'(track_len) - 1) begin
                    p = keyframe_pose(track[track_len - 1], WHERE_LAST);
                end else begin
                    p.x     = blend_coord(track[idx].x, track[idx + 1].x, rem, ivl);
                    p.y     = blend_coord(track[idx].y, track[idx + 1].y, rem, ivl);
                    p.rot   = blend_coord(track[idx].rot, track[idx + 1].rot, rem, ivl);
                    p.where = WHERE_LERP;
                end
            end
            pending_poses.push_back(p);
        endfunction

        task check_result(t_pose got);
            t_pose e;
            if (pending_poses.size() == 0) begin
                report_mismatch("pose returned with no query outstanding");
                return;
            end
            e = pending_poses.pop_front();
            where_seen[e.where]++;
            if (got.x !== e.x)
                report_mismatch($sformatf("pos_x_q8 got %0d want %0d", got.x, e.x));
            if (got.y !== e.y)
                report_mismatch($sformatf("pos_y_q8 got %0d want %0d", got.y, e.y));
            if (got.rot !== e.rot)
                report_mismatch($sformatf("rot_q8 got %0d want %0d", got.rot, e.rot));
            if (got.where !== e.where)
                report_mismatch($sformatf("where_case got %0d want %0d", got.where, e.where));
        endtask
    endclass

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [IVL_W-1:0]             i_cfg_interval_ticks = '0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_ready;
    logic                         i_cmd = 1'b0;
    logic                         i_start_new = 1'b0;
    logic signed [COORD_W-1:0]    i_frame_x = '0;
    logic signed [COORD_W-1:0]    i_frame_y = '0;
    logic signed [COORD_W-1:0]    i_frame_rot = '0;
    logic signed [TIME_W-1:0]     i_race_time = '0;
    logic                         o_out_valid;
    logic                         i_out_ready = 1'b0;
    logic signed [Q8_W-1:0]       o_pos_x_q8;
    logic signed [Q8_W-1:0]       o_pos_y_q8;
    logic signed [Q8_W-1:0]       o_rot_q8;
    logic [1:0]                   o_where_case;

    pose_tracker sb = new;
    bit          idle_on = 1'b0;
    bit          phase_idling = 1'b0;
    int unsigned settings_used = 0;
    int unsigned cycle_count = 0;

    keyframe_track_interpolator uut (.*);

    // 12-unit clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles, %0d poses still owed", cycle_count,
                     sb.pending_poses.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: ready with random stall bursts
    initial begin
        forever begin
            @(posedge i_clk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(0, 15)) @(posedge i_clk);
        end
    end

    // Result checking
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result('{o_pos_x_q8, o_pos_y_q8, o_rot_q8, t_where'(o_where_case)});
    end

    // One request, with an optional gap in front of it
    task automatic send_request(t_cmd c, logic sn, logic signed [COORD_W-1:0] fx,
                                logic signed [COORD_W-1:0] fy, logic signed [COORD_W-1:0] fr,
                                logic signed [TIME_W-1:0] t);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_cmd       <= c;
        i_start_new <= sn;
        i_frame_x   <= fx;
        i_frame_y   <= fy;
        i_frame_rot <= fr;
        i_race_time <= t;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_request(c, sn, t_frame'{fx, fy, fr}, t);
    endtask

    function automatic logic signed [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            default: return COORD_W'($urandom);
        endcase
    endfunction

    // Mostly times inside the track, some past the end, some not positive
    function automatic logic signed [TIME_W-1:0] pick_time();
        longint ivl;
        longint t;
        int unsigned last_seg;
        ivl      = (sb.interval == '0) ? 1 : longint'(sb.interval);
        last_seg = (sb.track_len > 1) ? sb.track_len - 2 : 0;
        case ($urandom_range(0, 9))
            0: return TIME_W'($urandom);
            1: return -TIME_W'($urandom_range(0, 1000));
            2: t = longint'(sb.track_len - 1) * ivl + longint'($urandom_range(0, 32'(2 * ivl)));
            default:
                t = longint'($urandom_range(0, last_seg)) * ivl
                    + longint'($urandom_range(0, 32'(ivl - 1)));
        endcase
        if (t > 64'sh7FFF_FFFF)
            t = longint'($urandom_range(1, 32'h7FFF_FFFF));
        return TIME_W'(t);
    endfunction

    task automatic load_frame(logic sn);
        send_request(CMD_LOAD, sn, pick_coord(), pick_coord(), pick_coord(), TIME_W'($urandom));
    endtask

    task automatic query_at(logic signed [TIME_W-1:0] t);
        send_request(CMD_QUERY, 1'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                     COORD_W'($urandom), t);
    endtask

    // Stop sending, let every owed pose arrive and the block settle
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        while (sb.pending_poses.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_interval(logic [IVL_W-1:0] v);
        i_cfg_valid          <= 1'b1;
        i_cfg_interval_ticks <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.interval = v;
        settings_used++;
    endtask

    // Edge cases at the reset interval of 100000 ticks
    task automatic run_directed();
        query_at(32'sd5000);                 // empty track
        query_at(-32'sd7);
        send_request(CMD_LOAD, 1'b0, 16'sh7FFF, 16'sh8000, 16'sh0000, 32'sd0);
        query_at(32'sd250000);               // single frame
        send_request(CMD_LOAD, 1'b0, 16'sh8000, 16'sh7FFF, 16'shFFFF, 32'sd0);
        send_request(CMD_LOAD, 1'b0, 16'sh0000, 16'sh0001, 16'sd3600, 32'sd0);
        // restart the track: only the next three frames remain
        send_request(CMD_LOAD, 1'b1, 16'sd100, -16'sd100, -16'sd3600, 32'sd0);
        send_request(CMD_LOAD, 1'b0, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 32'sd0);
        send_request(CMD_LOAD, 1'b0, 16'sh7FFF, 16'sh8000, 16'sh8000, 32'sd0);
        query_at(32'sd0);
        query_at(-32'sd1);
        query_at(32'sh8000_0000);
        query_at(32'sd1);
        query_at(32'sd99999);
        query_at(32'sd100000);               // exactly on a keyframe
        query_at(32'sd150000);               // full-scale swing between extremes
        query_at(32'sd199999);
        query_at(32'sd200000);               // past the end
        query_at(32'sh7FFF_FFFF);
    endtask

    // Well-formed tracks with random content, a few broken restarts and noisy times
    task automatic run_episodes(int unsigned n_items);
        int unsigned target;
        int unsigned n_frames;
        target = sb.loads + sb.queries + n_items;
        while (sb.loads + sb.queries < target) begin
            idle_on  = phase_idling && ($urandom_range(0, 3) != 0);
            n_frames = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60)
                                                   : $urandom_range(1, 12);
            load_frame(1'b1);
            repeat (n_frames - 1) load_frame($urandom_range(0, 29) == 0);
            repeat ($urandom_range(2, 10)) begin
                if ($urandom_range(0, 11) == 0)
                    load_frame(1'b0);
                query_at(pick_time());
            end
        end
    endtask

    task automatic run_phase(logic [IVL_W-1:0] ivl, int unsigned n_items, bit idling);
        wait_for_drain();
        write_interval(ivl);
        phase_idling = idling;
        run_episodes(n_items);
    endtask

    // Main sequence
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idle_on = 1'b1;
        run_directed();
        run_phase(24'd1, 110, 1'b1);
        run_phase('0, 90, 1'b1);             // zero interval acts as one tick
        run_phase(24'hFF_FFFF, 110, 1'b1);
        run_phase(IVL_W'($urandom_range(2, 40)), 110, 1'b1);
        run_phase(IVL_W'($urandom_range(1, 24'hFF_FFFF)), 110, 1'b1);
        run_phase(IVL_RESET, 100, 1'b1);
        idle_on = 1'b0;
        run_phase(IVL_W'($urandom_range(41, 5000)), 150, 1'b0);
        wait_for_drain();

        $display("Sent %0d loads (%0d dropped) and %0d queries over %0d interval",
                 sb.loads, sb.dropped, sb.queries, settings_used);
        $display("settings; poses checked: %0d interpolated, %0d first, %0d last; %0d mismatches",
                 sb.where_seen[WHERE_LERP], sb.where_seen[WHERE_FIRST],
                 sb.where_seen[WHERE_LAST], sb.errors);
        if (sb.errors == 0 && sb.pending_poses.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
